>>> src/goi_pkg.sv
// Shared types and constants for the Geneve option inserter.
package goi_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_FRAME_BYTES_DEF  = 16384;
   localparam int MAX_OPTION_BYTES_DEF = 252;

   // Queue depths
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // Configuration register indexes
   localparam logic CSR_INSERT_ENABLE  = 1'b0;
   localparam logic CSR_VPC_IDENTIFIER = 1'b1;

   // Header fields
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
   localparam logic [15:0] GNV_UDP_PORT  = 16'd6081;
   localparam logic [3:0]  IHL_MIN       = 4'd5;

   // Fixed byte offsets inside the frame
   localparam int POS_ETYPE_HI = 12;
   localparam int POS_ETYPE_LO = 13;
   localparam int POS_IP_VHL   = 14;
   localparam int POS_IP_PROTO = 23;
   localparam int ETH_HDR_BYTES = 14;
   localparam int UDP_DPORT_HI  = 2;
   localparam int UDP_DPORT_LO  = 3;
   localparam int GNV_OPTLEN    = 8;   // offset of option-length byte from UDP start
   localparam int GNV_OPT_START = 16;  // offset of first option byte from UDP start

   // Inserted option
   localparam logic [15:0] NEW_TLV_CLASS = 16'd1001;
   localparam logic [7:0]  NEW_TLV_KIND  = 8'd10;
   localparam logic [7:0]  OPT_LEN_WORDS = 8'd1;
   localparam int          OPT_BYTES     = 8;
   localparam logic [5:0]  OPT_LEN_INC   = 6'd2;

   // Beat counter in the back end: 0 is the frame byte, 1..8 the option
   localparam int BEAT_W = 4;

   // Word from the front end to the back end
   typedef struct packed {
      logic [7:0] byte_val;
      logic       last;
      logic       ins;       // append the 8-byte option after this byte
      logic       verdict;
      logic       inserted;
   } cmd_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       verdict;
      logic       was_inserted;
   } rsp_type;

endpackage

>>> src/goi_fifo.sv
// Small register FIFO with show-ahead head word.
module goi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/goi_front.sv
// Front end: parses the header bytes and classifies each frame byte.
module goi_front #(
   parameter int MAX_FRAME_BYTES  = goi_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_OPTION_BYTES = goi_pkg::MAX_OPTION_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   input  logic             insert_enable,
   output goi_pkg::cmd_type cmd
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES);
   // Compare width covers both frame positions and header offsets (up to 342)
   localparam int CMP_W = (POS_W >= 10) ? POS_W + 1 : 11;

   typedef enum logic [2:0] {
      PH_ETH,
      PH_IP,
      PH_UDP,
      PH_GENEVE,
      PH_PASS,
      PH_MATCHED
   } phase_type;

   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in, phase_mid;
   logic [5:0]       ihl_bytes_ff, ihl_bytes_in;
   logic [7:0]       held_ff, held_in;
   logic [CMP_W-1:0] opt_end_ff, opt_end_in, opt_end_mid;
   logic             match_ff, match_in, match_mid;
   logic             pending_ff, pending_in, pending_mid;
   logic             done_ff, done_in;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] udp_start;
   logic [8:0]       opt_grown;
   logic [7:0]       out_b;
   logic             fire;

   assign pos_x     = CMP_W'(pos_ff);
   assign udp_start = CMP_W'(goi_pkg::ETH_HDR_BYTES) + CMP_W'(ihl_bytes_ff);
   assign opt_grown = {1'b0, in_byte[5:0], 2'b00} + 9'(goi_pkg::OPT_BYTES);

   // Header parse for the current byte
   always_comb begin
      phase_mid    = phase_ff;
      ihl_bytes_in = ihl_bytes_ff;
      held_in      = held_ff;
      opt_end_mid  = opt_end_ff;
      match_mid    = match_ff;
      pending_mid  = pending_ff;
      out_b        = in_byte;
      case (phase_ff)
         PH_ETH: begin
            if (pos_x == CMP_W'(goi_pkg::POS_ETYPE_HI)) begin
               held_in = in_byte;
            end else if (pos_x == CMP_W'(goi_pkg::POS_ETYPE_LO)) begin
               phase_mid = ({held_ff, in_byte} == goi_pkg::ETH_TYPE_IPV4) ? PH_IP : PH_PASS;
            end
         end
         PH_IP: begin
            if (pos_x == CMP_W'(goi_pkg::POS_IP_VHL)) begin
               if (in_byte[3:0] < goi_pkg::IHL_MIN) begin
                  phase_mid = PH_PASS;
               end else begin
                  ihl_bytes_in = {in_byte[3:0], 2'b00};
               end
            end else if (pos_x == CMP_W'(goi_pkg::POS_IP_PROTO)) begin
               phase_mid = (in_byte == goi_pkg::IP_PROTO_UDP) ? PH_UDP : PH_PASS;
            end
         end
         PH_UDP: begin
            if (pos_x == udp_start + CMP_W'(goi_pkg::UDP_DPORT_HI)) begin
               held_in = in_byte;
            end else if (pos_x == udp_start + CMP_W'(goi_pkg::UDP_DPORT_LO)) begin
               phase_mid = ({held_ff, in_byte} == goi_pkg::GNV_UDP_PORT) ? PH_GENEVE : PH_PASS;
            end
         end
         PH_GENEVE: begin
            if (pos_x == udp_start + CMP_W'(goi_pkg::GNV_OPTLEN)) begin
               if (opt_grown > 9'(MAX_OPTION_BYTES)) begin
                  phase_mid = PH_PASS;
               end else begin
                  phase_mid   = PH_MATCHED;
                  match_mid   = 1'b1;
                  opt_end_mid = udp_start + CMP_W'(goi_pkg::GNV_OPT_START)
                              + CMP_W'({in_byte[5:0], 2'b00});
                  if (insert_enable) begin
                     pending_mid = 1'b1;
                     out_b       = {in_byte[7:6], in_byte[5:0] + goi_pkg::OPT_LEN_INC};
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Option goes right after the last existing option byte
   assign fire = pending_mid && (pos_x + 1'b1 == opt_end_mid);

   // Classified word for the back end
   always_comb begin
      cmd.byte_val = out_b;
      cmd.last     = in_last;
      cmd.ins      = fire;
      cmd.verdict  = in_last && match_mid && !(pending_mid && !fire);
      cmd.inserted = in_last && (done_ff || fire);
   end

   // Next frame state
   always_comb begin
      pos_in     = pos_ff;
      phase_in   = phase_mid;
      opt_end_in = opt_end_mid;
      match_in   = match_mid;
      pending_in = pending_mid && !fire;
      done_in    = done_ff || fire;
      if (in_last) begin
         pos_in     = '0;
         phase_in   = PH_ETH;
         opt_end_in = '0;
         match_in   = 1'b0;
         pending_in = 1'b0;
         done_in    = 1'b0;
      end else if (pos_ff != POS_W'(MAX_FRAME_BYTES - 1)) begin
         pos_in = pos_ff + 1'b1;
      end else if (phase_mid == PH_ETH || phase_mid == PH_IP ||
                   phase_mid == PH_UDP || phase_mid == PH_GENEVE) begin
         // Overlong frame still in the headers
         phase_in = PH_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_ETH;
         ihl_bytes_ff <= '0;
         held_ff      <= '0;
         opt_end_ff   <= '0;
         match_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else if (in_valid) begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         ihl_bytes_ff <= in_last ? '0 : ihl_bytes_in;
         held_ff      <= in_last ? '0 : held_in;
         opt_end_ff   <= opt_end_in;
         match_ff     <= match_in;
         pending_ff   <= pending_in;
         done_ff      <= done_in;
      end
   end

endmodule

>>> src/goi_back.sv
// Back end: emits each frame byte and, where marked, the 8-byte option.
module goi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_avail,
   input  goi_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_room,
   output logic             rsp_put,
   output goi_pkg::rsp_type rsp,
   input  logic [31:0]      vpc_identifier
);

   logic [goi_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                       final_beat;
   logic [7:0]                 beat_byte;

   assign final_beat = !cmd.ins || (beat_ff == goi_pkg::BEAT_W'(goi_pkg::OPT_BYTES));
   assign rsp_put    = cmd_avail && rsp_room;
   assign cmd_take   = rsp_put && final_beat;

   // Byte for the current beat
   always_comb begin
      case (beat_ff)
         4'd0:    beat_byte = cmd.byte_val;
         4'd1:    beat_byte = goi_pkg::NEW_TLV_CLASS[15:8];
         4'd2:    beat_byte = goi_pkg::NEW_TLV_CLASS[7:0];
         4'd3:    beat_byte = goi_pkg::NEW_TLV_KIND;
         4'd4:    beat_byte = goi_pkg::OPT_LEN_WORDS;
         4'd5:    beat_byte = vpc_identifier[7:0];
         4'd6:    beat_byte = vpc_identifier[15:8];
         4'd7:    beat_byte = vpc_identifier[23:16];
         4'd8:    beat_byte = vpc_identifier[31:24];
         default: beat_byte = cmd.byte_val;
      endcase
   end

   // Status flags ride on the frame's final output byte only
   always_comb begin
      rsp.out_byte     = beat_byte;
      rsp.out_last     = cmd.last && final_beat;
      rsp.verdict      = cmd.verdict && final_beat;
      rsp.was_inserted = cmd.inserted && final_beat;
   end

   always_comb begin
      beat_in = beat_ff;
      if (rsp_put) begin
         beat_in = final_beat ? '0 : beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

endmodule

>>> src/geneve_option_inserter.sv
// Top level of the Geneve option inserter: CSRs, front end, queues, back end.
//
// Input is a byte queue: present req_data_byte/req_last_byte with push; a word
// is taken at a clock edge where push is high and full is low. Frames start at
// the Ethernet header. Output is a byte queue: while empty is low the oldest
// result word is on the rsp_ ports; pop takes it. verdict and was_inserted are
// meaningful on the word with rsp_out_last set and are 0 elsewhere.
// A taken byte passes through the command queue and then the result queue.
// Throughput: one byte per cycle in and out while no queue is full. For a
// frame that gets the option, the back end keeps the byte ahead of it at the
// head of the command queue while it emits that byte and the option bytes;
// the command queue can then fill, and full holds input off until it drains.
// When the receiver stops popping, the 2-entry result queue and then the
// command queue fill and full rises; nothing is dropped.
// The CSR port writes insert_enable (index 0) or vpc_identifier (index 1);
// write only while the block is idle.
// Reset (synchronous) empties both queues, clears the parser and the CSRs.
module geneve_option_inserter #(
   parameter int MAX_FRAME_BYTES  = goi_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_OPTION_BYTES = goi_pkg::MAX_OPTION_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input byte queue
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result byte queue
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_verdict,
   output logic        rsp_was_inserted,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic             insert_enable_ff;
   logic [31:0]      vpc_identifier_ff;
   logic             accept;
   goi_pkg::cmd_type cmd_w, cmd_head;
   logic             cmd_full, cmd_empty, cmd_take;
   goi_pkg::rsp_type rsp_w, rsp_head;
   logic             rsp_full, rsp_put;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         insert_enable_ff  <= 1'b0;
         vpc_identifier_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            goi_pkg::CSR_INSERT_ENABLE:  insert_enable_ff  <= csr_wdata[0];
            goi_pkg::CSR_VPC_IDENTIFIER: vpc_identifier_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   goi_front #(
      .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
      .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_byte       (req_data_byte),
      .in_last       (req_last_byte),
      .insert_enable (insert_enable_ff),
      .cmd           (cmd_w)
   );

   // Queue between front and back end
   goi_fifo #(
      .WIDTH ($bits(goi_pkg::cmd_type)),
      .DEPTH (goi_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (cmd_w),
      .rd_en   (cmd_take),
      .rd_data (cmd_head),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   goi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_avail      (!cmd_empty),
      .cmd            (cmd_head),
      .cmd_take       (cmd_take),
      .rsp_room       (!rsp_full),
      .rsp_put        (rsp_put),
      .rsp            (rsp_w),
      .vpc_identifier (vpc_identifier_ff)
   );

   // Result queue
   goi_fifo #(
      .WIDTH ($bits(goi_pkg::rsp_type)),
      .DEPTH (goi_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_put),
      .wr_data (rsp_w),
      .rd_en   (pop),
      .rd_data (rsp_head),
      .full    (rsp_full),
      .empty   (empty)
   );

   assign rsp_out_byte     = rsp_head.out_byte;
   assign rsp_out_last     = rsp_head.out_last;
   assign rsp_verdict      = rsp_head.verdict;
   assign rsp_was_inserted = rsp_head.was_inserted;

endmodule
